FILE: rtl/kpsq_pkg.sv
// kpsq_pkg: shared types, codes and key-map lookup for the keypad scan queue.
// No dependencies; the channel interfaces and the top level import it.
package kpsq_pkg;

  localparam int REQ_W      = 2;
  localparam int COL_W      = 4;
  localparam int ROW_DRV_W  = 4;
  localparam int KEY_W      = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DEB_W      = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH = 2'd2;

  localparam logic [DEB_W-1:0]      DEBOUNCE_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] MAP_LOW_RST  = 32'hB654_A321;
  localparam logic [CFG_DATA_W-1:0] MAP_HIGH_RST = 32'hDF0E_C987;

  // Key code of a matrix position; positions outside the 4x4 map give zero.
  function automatic logic [KEY_W-1:0] key_code(input logic [CFG_DATA_W-1:0] map_lo,
                                                input logic [CFG_DATA_W-1:0] map_hi,
                                                input logic [2:0] row,
                                                input logic [2:0] col);
    logic [CFG_DATA_W-1:0] word;
    logic [4:0]            sh;
    word = row[1] ? map_hi : map_lo;
    sh   = {row[0], col[1:0], 2'b00};
    if (row[2] || col[2]) begin
      return '0;
    end
    return KEY_W'(word >> sh);
  endfunction

endpackage

FILE: rtl/kpsq_if.sv
// kpsq_if: valid/ready channel interfaces for requests and results.
// Depends on kpsq_pkg for the payload widths.
interface kpsq_in_if
  import kpsq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [COL_W-1:0]   col_lines;
  logic               trigger_line;

  modport source (output valid, req_type, col_lines, trigger_line, input ready);
  modport sink   (input valid, req_type, col_lines, trigger_line, output ready);
endinterface

interface kpsq_out_if
  import kpsq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ROW_DRV_W-1:0] row_drive;
  logic                 read_valid;
  logic [KEY_W-1:0]     read_key;
  logic [COUNT_W-1:0]   queue_count;
  logic                 scanning;
  logic                 key_dropped;

  modport source (output valid, row_drive, read_valid, read_key, queue_count, scanning,
                  key_dropped, input ready);
  modport sink   (input valid, row_drive, read_valid, read_key, queue_count, scanning,
                  key_dropped, output ready);
endinterface

FILE: rtl/matrix_keypad_scan_queue_top.sv
// matrix_keypad_scan_queue_top: 4x4 keypad scanner with banked key-code queue.
// Depends on kpsq_pkg and the channel interfaces in kpsq_if.sv.
//
//   channel  | direction | handshake          | carries
//   ---------+-----------+--------------------+--------------------------------------
//   in_ch    | in        | valid/ready        | req_type, col_lines, trigger_line
//   out_ch   | out       | valid/ready        | row_drive, read_valid, read_key, ...
//   cfg_*    | in        | cfg_we, no wait    | cfg_index, cfg_wdata
//
// One request per cycle while the result is not stalled; its result is valid the cycle after acceptance.
// The queue sits in one bank per column lane, so a scan tick writes all its accepted
// codes together; a read takes its key from the banks' registered read port.
// Reset clears pointers, fill, scan state and config registers; queue contents stay.
// A stalled result holds, and a new request is taken in the cycle it drains.
module matrix_keypad_scan_queue_top
  import kpsq_pkg::*;
#(
  parameter int ROW_COUNT   = 4,
  parameter int COL_COUNT   = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kpsq_in_if.sink               in_ch,
  kpsq_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LANES = (COL_COUNT < COL_W) ? COL_COUNT : COL_W;
  localparam int BW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int RPB   = (QUEUE_DEPTH + LANES - 1) / LANES;
  localparam int RW    = (RPB > 1) ? $clog2(RPB) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int KW    = (FW > 3) ? FW : 3;
  localparam int RIW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_SCAN} phase_t;

  phase_t                phase_r, phase_nxt;
  logic [RIW-1:0]        row_r, row_nxt;
  logic [DEB_W-1:0]      wait_r, wait_nxt;
  logic                  last_trig_r, last_trig_nxt;
  logic [BW-1:0]         head_bank_r, head_bank_nxt, tail_bank_r, tail_bank_nxt;
  logic [RW-1:0]         head_row_r, head_row_nxt, tail_row_r, tail_row_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;

  logic [DEB_W-1:0]      debounce_r;
  logic [CFG_DATA_W-1:0] map_lo_r, map_hi_r;

  logic                  out_valid_r;
  logic [ROW_DRV_W-1:0]  drive_r, drive_nxt;
  logic                  rvalid_r, rvalid_nxt;
  logic [BW-1:0]         rd_bank_r;
  logic [COUNT_W-1:0]    count_r;
  logic                  scanning_r;
  logic                  dropped_r, dropped_nxt;

  logic                  in_ready_w, accept;
  logic                  rd_en, push_go;

  logic [KEY_W-1:0]      code_w   [LANES];
  logic [2:0]            rank_w   [LANES];
  logic [LANES-1:0]      active_w;
  logic [2:0]            n_act, n_acc;
  logic [KW-1:0]         room;

  logic [LANES-1:0]      bank_we;
  logic [RW-1:0]         bank_wrow  [LANES];
  logic [KEY_W-1:0]      bank_wdata [LANES];
  logic [KEY_W-1:0]      bank_q     [LANES];

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == RW'(RPB - 1)) ? '0 : RW'(r + 1'b1);
  endfunction

  assign in_ready_w = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ready_w;
  assign rd_en      = accept && (in_ch.req_type == REQ_READ);
  assign push_go    = accept && (in_ch.req_type == REQ_TICK) && (phase_r == PH_SCAN);

  // codes of the driven row, and each active column's place in push order
  always_comb begin
    logic [2:0] cnt;
    cnt = '0;
    for (int c = 0; c < LANES; c++) begin
      code_w[c]   = key_code(map_lo_r, map_hi_r, 3'(row_r), 3'(c));
      active_w[c] = in_ch.col_lines[c];
      rank_w[c]   = cnt;
      cnt         = cnt + 3'(active_w[c]);
    end
    n_act = cnt;
    room  = KW'(QUEUE_DEPTH) - KW'(fill_r);
    n_acc = (KW'(n_act) < room) ? n_act : 3'(room);
  end

  // steer accepted codes to banks: lane offset from tail picks the code
  always_comb begin
    logic [2:0] d;
    for (int b = 0; b < LANES; b++) begin
      if (3'(b) >= 3'(tail_bank_r)) begin
        d = 3'(b) - 3'(tail_bank_r);
      end else begin
        d = 3'(b) + 3'(LANES) - 3'(tail_bank_r);
      end
      bank_we[b]    = push_go && (d < n_acc);
      bank_wrow[b]  = (3'(b) < 3'(tail_bank_r)) ? row_inc(tail_row_r) : tail_row_r;
      bank_wdata[b] = '0;
      for (int c = 0; c < LANES; c++) begin
        if (active_w[c] && (rank_w[c] == d)) begin
          bank_wdata[b] = code_w[c];
        end
      end
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [KEY_W-1:0] mem [RPB];
    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[bank_wrow[b]] <= bank_wdata[b];
      end
      if (rd_en) begin
        bank_q[b] <= mem[head_row_r];
      end
    end
  end

  always_comb begin
    logic [3:0] tsum;
    phase_nxt     = phase_r;
    row_nxt       = row_r;
    wait_nxt      = wait_r;
    last_trig_nxt = last_trig_r;
    head_bank_nxt = head_bank_r;
    head_row_nxt  = head_row_r;
    tail_bank_nxt = tail_bank_r;
    tail_row_nxt  = tail_row_r;
    fill_nxt      = fill_r;
    rvalid_nxt    = 1'b0;
    dropped_nxt   = 1'b0;
    tsum          = 4'(tail_bank_r) + 4'(n_acc);

    case (in_ch.req_type)
      REQ_TICK: begin
        last_trig_nxt = in_ch.trigger_line;
        case (phase_r)
          PH_DEBOUNCE: begin
            if (wait_r != '0) begin
              wait_nxt = wait_r - 1'b1;
            end else begin
              phase_nxt = PH_SCAN;
              row_nxt   = '0;
            end
          end
          PH_SCAN: begin
            fill_nxt    = fill_r + FW'(n_acc);
            dropped_nxt = (n_act != n_acc);
            if (tsum >= 4'(LANES)) begin
              tail_bank_nxt = BW'(tsum - 4'(LANES));
              tail_row_nxt  = row_inc(tail_row_r);
            end else begin
              tail_bank_nxt = BW'(tsum);
            end
            if (row_r == RIW'(ROW_COUNT - 1)) begin
              row_nxt   = '0;
              phase_nxt = PH_IDLE;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
          default: begin
            if (in_ch.trigger_line && !last_trig_r) begin
              phase_nxt = PH_DEBOUNCE;
              wait_nxt  = debounce_r;
            end
          end
        endcase
      end
      REQ_READ: begin
        if (fill_r != '0) begin
          rvalid_nxt = 1'b1;
          fill_nxt   = fill_r - 1'b1;
          if (head_bank_r == BW'(LANES - 1)) begin
            head_bank_nxt = '0;
            head_row_nxt  = row_inc(head_row_r);
          end else begin
            head_bank_nxt = head_bank_r + 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        head_bank_nxt = '0;
        head_row_nxt  = '0;
        tail_bank_nxt = '0;
        tail_row_nxt  = '0;
        fill_nxt      = '0;
      end
      default: ;
    endcase

    for (int r = 0; r < ROW_DRV_W; r++) begin
      if (phase_nxt == PH_SCAN) begin
        drive_nxt[r] = (32'(row_nxt) == r);
      end else begin
        drive_nxt[r] = (r < ROW_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      row_r       <= '0;
      wait_r      <= '0;
      last_trig_r <= 1'b0;
      head_bank_r <= '0;
      head_row_r  <= '0;
      tail_bank_r <= '0;
      tail_row_r  <= '0;
      fill_r      <= '0;
      debounce_r  <= DEBOUNCE_RST;
      map_lo_r    <= MAP_LOW_RST;
      map_hi_r    <= MAP_HIGH_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_r <= cfg_wdata[DEB_W-1:0];
          CFG_MAP_LOW:  map_lo_r   <= cfg_wdata;
          CFG_MAP_HIGH: map_hi_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        row_r       <= row_nxt;
        wait_r      <= wait_nxt;
        last_trig_r <= last_trig_nxt;
        head_bank_r <= head_bank_nxt;
        head_row_r  <= head_row_nxt;
        tail_bank_r <= tail_bank_nxt;
        tail_row_r  <= tail_row_nxt;
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // result payload: hold while stalled
    if (accept) begin
      drive_r    <= drive_nxt;
      rvalid_r   <= rvalid_nxt;
      rd_bank_r  <= head_bank_r;
      count_r    <= COUNT_W'(fill_nxt);
      scanning_r <= (phase_nxt != PH_IDLE);
      dropped_r  <= dropped_nxt;
    end
  end

  assign in_ch.ready        = in_ready_w;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_drive   = drive_r;
  assign out_ch.read_valid  = rvalid_r;
  assign out_ch.read_key    = rvalid_r ? bank_q[rd_bank_r] : '0;
  assign out_ch.queue_count = count_r;
  assign out_ch.scanning    = scanning_r;
  assign out_ch.key_dropped = dropped_r;

endmodule
